>>> rtl/core/bdq_pkg.sv
// Package for the bounded deque: field widths, operation and status codes,
// cell control codes and the control struct sent to every cell.
// No dependencies.
`timescale 1ns / 1ps

package bdq_pkg;

    localparam int VAL_W   = 32;
    localparam int KIND_W  = 3;
    localparam int OCC_W   = 7;
    localparam int STAT_W  = 2;
    localparam int DEPTH_DEFAULT = 32;

    // Operation kinds.
    localparam logic [KIND_W-1:0] KIND_PUSH_FRONT = 3'd0;
    localparam logic [KIND_W-1:0] KIND_PUSH_BACK  = 3'd1;
    localparam logic [KIND_W-1:0] KIND_POP_FRONT  = 3'd2;
    localparam logic [KIND_W-1:0] KIND_POP_BACK   = 3'd3;
    localparam logic [KIND_W-1:0] KIND_DELETE     = 3'd4;
    localparam logic [KIND_W-1:0] KIND_CLEAR      = 3'd5;
    localparam logic [KIND_W-1:0] KIND_READ_FRONT = 3'd6;
    localparam logic [KIND_W-1:0] KIND_READ_BACK  = 3'd7;

    // Result status codes.
    localparam logic [STAT_W-1:0] STAT_OK       = 2'd0;
    localparam logic [STAT_W-1:0] STAT_FULL     = 2'd1;
    localparam logic [STAT_W-1:0] STAT_EMPTY    = 2'd2;
    localparam logic [STAT_W-1:0] STAT_NOTFOUND = 2'd3;

    // Slot operations of a cell.
    localparam logic [2:0] SLOT_HOLD        = 3'd0;
    localparam logic [2:0] SLOT_SHIFT_BACK  = 3'd1;
    localparam logic [2:0] SLOT_SHIFT_FRONT = 3'd2;
    localparam logic [2:0] SLOT_LOAD_AT_CNT = 3'd3;
    localparam logic [2:0] SLOT_DELETE      = 3'd4;

    // Shadow (read-out) operations of a cell.
    localparam logic [1:0] SHAD_HOLD        = 2'd0;
    localparam logic [1:0] SHAD_COPY        = 2'd1;
    localparam logic [1:0] SHAD_TO_FRONT    = 2'd2;
    localparam logic [1:0] SHAD_TO_BACK     = 2'd3;

    typedef struct packed {
        logic [2:0]       slot_op;
        logic [1:0]       shadow_op;
        logic             capture;
        logic [OCC_W-1:0] count;
        logic [VAL_W-1:0] value;
    } cell_ctl_t;

endpackage

>>> rtl/core/bdq_cell.sv
// One cell of the deque chain: a stored slot, a shadow copy used for read-out
// and a registered match flag for delete. Depends on bdq_pkg.
`timescale 1ns / 1ps

module bdq_cell #(
    parameter int IDX = 0
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  bdq_pkg::cell_ctl_t          ctl,
    input  logic [bdq_pkg::VAL_W-1:0]   prev_slot,
    input  logic [bdq_pkg::VAL_W-1:0]   next_slot,
    input  logic [bdq_pkg::VAL_W-1:0]   prev_shadow,
    input  logic [bdq_pkg::VAL_W-1:0]   next_shadow,
    input  logic                        seen_in,
    output logic [bdq_pkg::VAL_W-1:0]   slot,
    output logic [bdq_pkg::VAL_W-1:0]   shadow,
    output logic                        seen_out
);

    localparam logic [bdq_pkg::OCC_W-1:0] MY_IDX = bdq_pkg::OCC_W'(IDX);

    logic [bdq_pkg::VAL_W-1:0] slot_reg;
    logic [bdq_pkg::VAL_W-1:0] slot_next;
    logic [bdq_pkg::VAL_W-1:0] shadow_reg;
    logic [bdq_pkg::VAL_W-1:0] shadow_next;
    logic                      match_reg;
    logic                      match_next;

    // The seen flag ripples from the front: it is high at and after the
    // first matching cell, and those cells close the gap.
    assign seen_out = seen_in | match_reg;
    assign slot     = slot_reg;
    assign shadow   = shadow_reg;

    always_comb
    begin
        case (ctl.slot_op)
            bdq_pkg::SLOT_HOLD:        slot_next = slot_reg;
            bdq_pkg::SLOT_SHIFT_BACK:  slot_next = prev_slot;
            bdq_pkg::SLOT_SHIFT_FRONT: slot_next = next_slot;
            bdq_pkg::SLOT_LOAD_AT_CNT: slot_next = (MY_IDX == ctl.count) ? ctl.value : slot_reg;
            bdq_pkg::SLOT_DELETE:      slot_next = seen_out ? next_slot : slot_reg;
            default:                   slot_next = slot_reg;
        endcase
    end

    always_comb
    begin
        case (ctl.shadow_op)
            bdq_pkg::SHAD_HOLD:     shadow_next = shadow_reg;
            bdq_pkg::SHAD_COPY:     shadow_next = slot_reg;
            bdq_pkg::SHAD_TO_FRONT: shadow_next = next_shadow;
            bdq_pkg::SHAD_TO_BACK:  shadow_next = prev_shadow;
            default:                shadow_next = shadow_reg;
        endcase
    end

    assign match_next = ctl.capture ? ((slot_reg == ctl.value) && (MY_IDX < ctl.count))
                                    : match_reg;

    always_ff @(posedge clk)
    begin
        slot_reg   <= slot_next;
        shadow_reg <= shadow_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            match_reg <= 1'b0;
        end
        else
        begin
            match_reg <= match_next;
        end
    end

endmodule

>>> rtl/core/bounded_deque_with_delete.sv
// Top level of the bounded deque: sequencer, output register and the cell chain.
// Depends on bdq_pkg and bdq_cell.
`timescale 1ns / 1ps

// Bounded double-ended queue of DEPTH signed 32-bit values held in a chain of
// cells, slot 0 at the front. Push front, push back, pop front, pop back and
// clear each return one result beat. For a delete, every cell compares its
// slot when the item is taken; then, once the output is free, a flag ripples
// down the chain so that the cells from the first match onward shift toward
// the front. A read with n = min(read_count, occupancy) > 0 copies the slots
// into the shadow chain and then returns one beat per cycle while the output
// is not stalled, n beats in all; a read from the back first slides the
// shadow chain so the back element sits at the chain's far end. A read with
// nothing to return gives one beat. The next item can be taken at the same
// edge at which the last result beat is accepted.
module bounded_deque_with_delete #(
    parameter int DEPTH = bdq_pkg::DEPTH_DEFAULT
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic [bdq_pkg::KIND_W-1:0]        kind,
    input  logic signed [bdq_pkg::VAL_W-1:0]  value,
    input  logic [bdq_pkg::OCC_W-1:0]         read_count,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic signed [bdq_pkg::VAL_W-1:0]  element,
    output logic [bdq_pkg::STAT_W-1:0]        status,
    output logic [bdq_pkg::OCC_W-1:0]         occupancy,
    output logic                              last
);

    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);
    localparam logic [CW-1:0] ONE_C   = CW'(1);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_DEL   = 2'd1;
    localparam logic [1:0] ST_ALIGN = 2'd2;
    localparam logic [1:0] ST_READ  = 2'd3;

    logic [1:0]    state_reg, state_next;
    logic [CW-1:0] count_reg, count_next;
    logic [CW-1:0] remain_reg, remain_next;
    logic [CW-1:0] align_reg, align_next;
    logic          back_reg, back_next;

    logic                          out_valid_reg, out_valid_next;
    logic [bdq_pkg::VAL_W-1:0]     element_reg, element_next;
    logic [bdq_pkg::STAT_W-1:0]    status_reg, status_next;
    logic [bdq_pkg::OCC_W-1:0]     occ_reg, occ_next;
    logic                          last_reg, last_next;

    bdq_pkg::cell_ctl_t ctl;

    logic [bdq_pkg::VAL_W-1:0] slot_w   [DEPTH];
    logic [bdq_pkg::VAL_W-1:0] shadow_w [DEPTH];
    logic [bdq_pkg::VAL_W-1:0] prev_slot_w   [DEPTH];
    logic [bdq_pkg::VAL_W-1:0] next_slot_w   [DEPTH];
    logic [bdq_pkg::VAL_W-1:0] prev_shadow_w [DEPTH];
    logic [bdq_pkg::VAL_W-1:0] next_shadow_w [DEPTH];
    logic [DEPTH:0]            seen_w;

    logic          out_free;
    logic          in_fire;
    logic          full;
    logic          empty;
    logic [CW-1:0] n_req;

    assign out_free = !out_valid_reg || out_ready;
    assign in_ready = (state_reg == ST_IDLE) && out_free;
    assign in_fire  = in_valid && in_ready;
    assign full     = (count_reg == DEPTH_C);
    assign empty    = (count_reg == '0);
    assign n_req    = (read_count < bdq_pkg::OCC_W'(count_reg)) ? CW'(read_count) : count_reg;

    assign seen_w[0] = 1'b0;

    genvar gi;
    generate
        for (gi = 0; gi < DEPTH; gi++)
        begin : g_cell
            if (gi == 0)
            begin : g_front
                assign prev_slot_w[gi]   = value;
                assign prev_shadow_w[gi] = '0;
            end
            else
            begin : g_inner_prev
                assign prev_slot_w[gi]   = slot_w[gi-1];
                assign prev_shadow_w[gi] = shadow_w[gi-1];
            end
            if (gi == DEPTH - 1)
            begin : g_back
                assign next_slot_w[gi]   = '0;
                assign next_shadow_w[gi] = '0;
            end
            else
            begin : g_inner_next
                assign next_slot_w[gi]   = slot_w[gi+1];
                assign next_shadow_w[gi] = shadow_w[gi+1];
            end

            bdq_cell #(
                .IDX (gi)
            ) u_cell (
                .clk         (clk),
                .rst_n       (rst_n),
                .ctl         (ctl),
                .prev_slot   (prev_slot_w[gi]),
                .next_slot   (next_slot_w[gi]),
                .prev_shadow (prev_shadow_w[gi]),
                .next_shadow (next_shadow_w[gi]),
                .seen_in     (seen_w[gi]),
                .slot        (slot_w[gi]),
                .shadow      (shadow_w[gi]),
                .seen_out    (seen_w[gi+1])
            );
        end
    endgenerate

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        remain_next    = remain_reg;
        align_next     = align_reg;
        back_next      = back_reg;
        out_valid_next = out_valid_reg && !out_ready;
        element_next   = element_reg;
        status_next    = status_reg;
        occ_next       = occ_reg;
        last_next      = last_reg;

        ctl.slot_op   = bdq_pkg::SLOT_HOLD;
        ctl.shadow_op = bdq_pkg::SHAD_HOLD;
        ctl.capture   = 1'b0;
        ctl.count     = bdq_pkg::OCC_W'(count_reg);
        ctl.value     = value;

        case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    out_valid_next = 1'b1;
                    element_next   = '0;
                    status_next    = bdq_pkg::STAT_OK;
                    last_next      = 1'b1;
                    case (kind)
                        bdq_pkg::KIND_PUSH_FRONT:
                        begin
                            if (full)
                            begin
                                status_next = bdq_pkg::STAT_FULL;
                            end
                            else
                            begin
                                ctl.slot_op = bdq_pkg::SLOT_SHIFT_BACK;
                                count_next  = count_reg + ONE_C;
                            end
                        end
                        bdq_pkg::KIND_PUSH_BACK:
                        begin
                            if (full)
                            begin
                                status_next = bdq_pkg::STAT_FULL;
                            end
                            else
                            begin
                                ctl.slot_op = bdq_pkg::SLOT_LOAD_AT_CNT;
                                count_next  = count_reg + ONE_C;
                            end
                        end
                        bdq_pkg::KIND_POP_FRONT:
                        begin
                            if (empty)
                            begin
                                status_next = bdq_pkg::STAT_EMPTY;
                            end
                            else
                            begin
                                ctl.slot_op = bdq_pkg::SLOT_SHIFT_FRONT;
                                count_next  = count_reg - ONE_C;
                            end
                        end
                        bdq_pkg::KIND_POP_BACK:
                        begin
                            if (empty)
                            begin
                                status_next = bdq_pkg::STAT_EMPTY;
                            end
                            else
                            begin
                                count_next = count_reg - ONE_C;
                            end
                        end
                        bdq_pkg::KIND_DELETE:
                        begin
                            if (empty)
                            begin
                                status_next = bdq_pkg::STAT_EMPTY;
                            end
                            else
                            begin
                                out_valid_next = 1'b0;
                                ctl.capture    = 1'b1;
                                state_next     = ST_DEL;
                            end
                        end
                        bdq_pkg::KIND_CLEAR:
                        begin
                            count_next = '0;
                        end
                        default:
                        begin
                            if (n_req == '0)
                            begin
                                status_next = empty ? bdq_pkg::STAT_EMPTY : bdq_pkg::STAT_OK;
                            end
                            else
                            begin
                                out_valid_next = 1'b0;
                                ctl.shadow_op  = bdq_pkg::SHAD_COPY;
                                remain_next    = n_req;
                                back_next      = (kind == bdq_pkg::KIND_READ_BACK);
                                align_next     = DEPTH_C - count_reg;
                                if ((kind == bdq_pkg::KIND_READ_BACK) && !full)
                                begin
                                    state_next = ST_ALIGN;
                                end
                                else
                                begin
                                    state_next = ST_READ;
                                end
                            end
                        end
                    endcase
                    occ_next = bdq_pkg::OCC_W'(count_next);
                end
            end
            ST_DEL:
            begin
                if (out_free)
                begin
                    ctl.slot_op    = bdq_pkg::SLOT_DELETE;
                    out_valid_next = 1'b1;
                    element_next   = '0;
                    last_next      = 1'b1;
                    if (seen_w[DEPTH])
                    begin
                        status_next = bdq_pkg::STAT_OK;
                        count_next  = count_reg - ONE_C;
                    end
                    else
                    begin
                        status_next = bdq_pkg::STAT_NOTFOUND;
                    end
                    occ_next   = bdq_pkg::OCC_W'(count_next);
                    state_next = ST_IDLE;
                end
            end
            ST_ALIGN:
            begin
                ctl.shadow_op = bdq_pkg::SHAD_TO_BACK;
                align_next    = align_reg - ONE_C;
                if (align_reg == ONE_C)
                begin
                    state_next = ST_READ;
                end
            end
            ST_READ:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    element_next   = back_reg ? shadow_w[DEPTH-1] : shadow_w[0];
                    status_next    = bdq_pkg::STAT_OK;
                    occ_next       = bdq_pkg::OCC_W'(count_reg);
                    last_next      = (remain_reg == ONE_C);
                    ctl.shadow_op  = back_reg ? bdq_pkg::SHAD_TO_BACK : bdq_pkg::SHAD_TO_FRONT;
                    remain_next    = remain_reg - ONE_C;
                    if (remain_reg == ONE_C)
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            remain_reg    <= '0;
            align_reg     <= '0;
            back_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            remain_reg    <= remain_next;
            align_reg     <= align_next;
            back_reg      <= back_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        element_reg <= element_next;
        status_reg  <= status_next;
        occ_reg     <= occ_next;
        last_reg    <= last_next;
    end

    assign out_valid = out_valid_reg;
    assign element   = element_reg;
    assign status    = status_reg;
    assign occupancy = occ_reg;
    assign last      = last_reg;

endmodule

>>> rtl/core/bdq_checker.sv
// Port-level checker for the bounded deque and the bind that attaches it.
// Depends on bdq_pkg and bounded_deque_with_delete.
`timescale 1ns / 1ps

module bdq_checker #(
    parameter int DEPTH = bdq_pkg::DEPTH_DEFAULT
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_ready,
    input  logic                              out_valid,
    input  logic                              out_ready,
    input  logic signed [bdq_pkg::VAL_W-1:0]  element,
    input  logic [bdq_pkg::STAT_W-1:0]        status,
    input  logic [bdq_pkg::OCC_W-1:0]         occupancy,
    input  logic                              last
);

    localparam logic [bdq_pkg::OCC_W-1:0] DEPTH_O = bdq_pkg::OCC_W'(DEPTH);

    // A stalled result beat holds its payload.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(element) && $stable(status)
                                    && $stable(occupancy) && $stable(last))
        else $error("result beat changed while stalled");

    // Any non-ok status comes on a single, final beat with a zero element.
    a_err_single: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status != bdq_pkg::STAT_OK) |-> last && (element == '0))
        else $error("error status on a non-final or nonzero beat");

    // A read that returns more than one beat needs stored elements.
    a_multi_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !last |-> (occupancy != '0))
        else $error("multi-beat read from an empty store");

    // Occupancy never exceeds the depth, and a rejected push sees a full store.
    a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (occupancy <= DEPTH_O)
                      && ((status != bdq_pkg::STAT_FULL) || (occupancy == DEPTH_O)))
        else $error("occupancy out of range");

    // No new item is taken in the middle of a multi-beat read.
    a_no_accept_mid_read: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !last && out_ready |-> !in_ready)
        else $error("item accepted during a read");

endmodule

bind bounded_deque_with_delete bdq_checker #(
    .DEPTH (DEPTH)
) u_bdq_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .element   (element),
    .status    (status),
    .occupancy (occupancy),
    .last      (last)
);
